FILE: rtl/tone_correlation_power_accumulator_defines.svh
// assertion macros for the tone correlation power accumulator
// no dependencies; define ASSERT_OFF to drop every check
`ifndef TONE_CORRELATION_POWER_ACCUMULATOR_DEFINES_SVH
`define TONE_CORRELATION_POWER_ACCUMULATOR_DEFINES_SVH

`ifndef ASSERT_OFF

// condition that must hold at every clock edge out of reset
`define TCPA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent now implies consequent on the next clock edge
`define TCPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define TCPA_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define TCPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/tcpa_pkg.sv
// shared types and constants for the tone correlation power accumulator
// no dependencies
package tcpa_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int PROD_W     = 32;
   localparam int DOT_W      = 64;
   localparam int ENERGY_W   = 63;
   localparam int RSP_COUNT_W = 32;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 400;

   // full-scale sample values, both counted as clipped
   localparam logic signed [SAMPLE_W-1:0] FULL_SCALE_POS = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] FULL_SCALE_NEG = 16'sh8000;

   // request command codes
   localparam logic CMD_ACCUMULATE = 1'b0;
   localparam logic CMD_CLEAR      = 1'b1;

   // one captured request
   typedef struct packed {
      logic                       cmd;
      logic signed [SAMPLE_W-1:0] mic_sample;
      logic signed [SAMPLE_W-1:0] ref_in_phase;
      logic signed [SAMPLE_W-1:0] ref_quadrature;
   } req_item_type;

endpackage

FILE: rtl/tone_correlation_power_accumulator.sv
// A request is registered in the input stage, then applied to the accumulators, which form the response register.
// Throughput: one request per cycle while rsp_tready stays high; a held response stalls input.
// Each response is the totals after its request; a clear request zeroes every sum.
// Reset (synchronous, active high) empties both stages and zeroes all accumulators.
// Depends on tcpa_pkg and tone_correlation_power_accumulator_defines.svh.
`include "tone_correlation_power_accumulator_defines.svh"

module tone_correlation_power_accumulator #(
   parameter int COUNT_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [15:0] mic_sample, [31:16] ref_in_phase, [47:32] ref_quadrature
   input  logic [tcpa_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] cmd
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [62:0] sample_energy, [126:63] in_phase_dot, [190:127] quadrature_dot,
   // [253:191] in_phase_energy, [316:254] quadrature_energy,
   // [332:317] peak_magnitude, [364:333] clipped_samples,
   // [396:365] samples_taken, [399:397] zero
   output logic [tcpa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] count_full
   output logic                            rsp_tuser
);

   import tcpa_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // input register stage
   req_item_type req_a_ff, req_a_in;
   logic         valid_a_ff, valid_a_in;
   logic         valid_r_ff, valid_r_in;
   logic         move_en;

   // accumulators, which double as the response register
   logic        [ENERGY_W-1:0]   energy_sum_ff, energy_sum_in;
   logic signed [DOT_W-1:0]      in_phase_corr_ff, in_phase_corr_in;
   logic signed [DOT_W-1:0]      quadrature_corr_ff, quadrature_corr_in;
   logic        [ENERGY_W-1:0]   in_phase_power_ff, in_phase_power_in;
   logic        [ENERGY_W-1:0]   quadrature_power_ff, quadrature_power_in;
   logic        [SAMPLE_W-1:0]   peak_level_ff, peak_level_in;
   logic        [COUNT_BITS-1:0] clip_tally_ff, clip_tally_in;
   logic        [COUNT_BITS-1:0] sample_tally_ff, sample_tally_in;

   logic signed [PROD_W-1:0]   prod_ss, prod_si, prod_sq, prod_ii, prod_qq;
   logic signed [SAMPLE_W:0]   mic_wide;
   logic        [SAMPLE_W:0]   mag_wide;
   logic        [SAMPLE_W-1:0] mag;
   logic                       is_clipped;
   logic                       count_full;

   // stage handshake: the input stage drains whenever the response slot frees
   assign move_en    = valid_a_ff && (!valid_r_ff || rsp_tready);
   assign req_tready = !valid_a_ff || move_en;

   always_comb begin
      valid_a_in = valid_a_ff;
      req_a_in   = req_a_ff;
      if (req_tready) begin
         valid_a_in = req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         req_a_in.cmd            = req_tuser;
         req_a_in.mic_sample     = req_tdata[15:0];
         req_a_in.ref_in_phase   = req_tdata[31:16];
         req_a_in.ref_quadrature = req_tdata[47:32];
      end
      valid_r_in = valid_r_ff;
      if (move_en) begin
         valid_r_in = 1'b1;
      end else if (rsp_tready) begin
         valid_r_in = 1'b0;
      end
   end

   // products of the registered request
   assign prod_ss = req_a_ff.mic_sample * req_a_ff.mic_sample;
   assign prod_si = req_a_ff.mic_sample * req_a_ff.ref_in_phase;
   assign prod_sq = req_a_ff.mic_sample * req_a_ff.ref_quadrature;
   assign prod_ii = req_a_ff.ref_in_phase * req_a_ff.ref_in_phase;
   assign prod_qq = req_a_ff.ref_quadrature * req_a_ff.ref_quadrature;

   // magnitude, with the most negative sample kept as 32768
   assign mic_wide   = {req_a_ff.mic_sample[SAMPLE_W-1], req_a_ff.mic_sample};
   assign mag_wide   = mic_wide[SAMPLE_W] ? (SAMPLE_W + 1)'(-mic_wide)
                                          : (SAMPLE_W + 1)'(mic_wide);
   assign mag        = mag_wide[SAMPLE_W-1:0];
   assign is_clipped = (req_a_ff.mic_sample == FULL_SCALE_POS) ||
                       (req_a_ff.mic_sample == FULL_SCALE_NEG);
   assign count_full = (sample_tally_ff == COUNT_MAX);

   // accumulator update
   always_comb begin
      energy_sum_in       = energy_sum_ff;
      in_phase_corr_in    = in_phase_corr_ff;
      quadrature_corr_in  = quadrature_corr_ff;
      in_phase_power_in   = in_phase_power_ff;
      quadrature_power_in = quadrature_power_ff;
      peak_level_in       = peak_level_ff;
      clip_tally_in       = clip_tally_ff;
      sample_tally_in     = sample_tally_ff;
      if (move_en) begin
         if (req_a_ff.cmd == CMD_CLEAR) begin
            energy_sum_in       = '0;
            in_phase_corr_in    = '0;
            quadrature_corr_in  = '0;
            in_phase_power_in   = '0;
            quadrature_power_in = '0;
            peak_level_in       = '0;
            clip_tally_in       = '0;
            sample_tally_in     = '0;
         end else if (!count_full) begin
            energy_sum_in       = energy_sum_ff + {31'b0, prod_ss};
            in_phase_corr_in    = in_phase_corr_ff + {{32{prod_si[PROD_W-1]}}, prod_si};
            quadrature_corr_in  = quadrature_corr_ff + {{32{prod_sq[PROD_W-1]}}, prod_sq};
            in_phase_power_in   = in_phase_power_ff + {31'b0, prod_ii};
            quadrature_power_in = quadrature_power_ff + {31'b0, prod_qq};
            if (mag > peak_level_ff) begin
               peak_level_in = mag;
            end
            if (is_clipped) begin
               clip_tally_in = clip_tally_ff + 1'b1;
            end
            sample_tally_in = sample_tally_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_a_ff <= req_a_in;
      if (reset) begin
         valid_a_ff          <= 1'b0;
         valid_r_ff          <= 1'b0;
         energy_sum_ff       <= '0;
         in_phase_corr_ff    <= '0;
         quadrature_corr_ff  <= '0;
         in_phase_power_ff   <= '0;
         quadrature_power_ff <= '0;
         peak_level_ff       <= '0;
         clip_tally_ff       <= '0;
         sample_tally_ff     <= '0;
      end else begin
         valid_a_ff          <= valid_a_in;
         valid_r_ff          <= valid_r_in;
         energy_sum_ff       <= energy_sum_in;
         in_phase_corr_ff    <= in_phase_corr_in;
         quadrature_corr_ff  <= quadrature_corr_in;
         in_phase_power_ff   <= in_phase_power_in;
         quadrature_power_ff <= quadrature_power_in;
         peak_level_ff       <= peak_level_in;
         clip_tally_ff       <= clip_tally_in;
         sample_tally_ff     <= sample_tally_in;
      end
   end

   // response packing
   assign rsp_tvalid = valid_r_ff;
   assign rsp_tuser  = count_full;
   assign rsp_tdata  = {3'b000,
                        RSP_COUNT_W'(sample_tally_ff),
                        RSP_COUNT_W'(clip_tally_ff),
                        peak_level_ff,
                        quadrature_power_ff,
                        in_phase_power_ff,
                        quadrature_corr_ff,
                        in_phase_corr_ff,
                        energy_sum_ff};

   // checks
   `TCPA_ASSERT_ALWAYS(a_clip_le_count, clock, reset, clip_tally_ff <= sample_tally_ff, "clip tally exceeds sample tally")
   `TCPA_ASSERT_NEXT(a_clear_zeroes, clock, reset, move_en && req_a_ff.cmd == CMD_CLEAR, sample_tally_ff == '0 && energy_sum_ff == '0 && peak_level_ff == '0, "clear left a sum behind")
   `TCPA_ASSERT_NEXT(a_hold_no_move, clock, reset, !move_en, $stable(energy_sum_ff) && $stable(sample_tally_ff) && $stable(in_phase_corr_ff), "accumulator changed without a request")
   `TCPA_ASSERT_NEXT(a_peak_monotone, clock, reset, move_en && req_a_ff.cmd == CMD_ACCUMULATE, peak_level_ff >= $past(peak_level_ff), "peak fell without a clear")
   `TCPA_ASSERT_NEXT(a_full_freezes, clock, reset, move_en && count_full && req_a_ff.cmd == CMD_ACCUMULATE, $stable(sample_tally_ff) && $stable(energy_sum_ff), "saturated count still accumulating")

endmodule

FILE: verif/tb_tone_correlation_power_accumulator.sv
// testbench for the tone correlation power accumulator: directed extremes and random
// traffic under three idling mixes, each response checked against a running
// prediction; depends on tcpa_pkg and the accumulator rtl
`timescale 1ns / 100ps

module tb_tone_correlation_power_accumulator;
   import tcpa_pkg::*;

   // counter width of the instance under test
   localparam int          COUNT_BITS_UNDER_TEST = 16;
   localparam logic [31:0] COUNT_LIMIT = 32'((64'd1 << COUNT_BITS_UNDER_TEST) - 64'd1);
   localparam int          CYCLE_LIMIT = 1_000_000;
   localparam int          RANDOM_ITEMS_PER_PHASE = 270;

   // totals reported by one response
   typedef struct {
      logic [62:0] sample_energy;
      logic [63:0] in_phase_dot;
      logic [63:0] quadrature_dot;
      logic [62:0] in_phase_energy;
      logic [62:0] quadrature_energy;
      logic [15:0] peak_magnitude;
      logic [31:0] clipped_samples;
      logic [31:0] samples_taken;
      logic        count_full;
   } totals_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [15:0] mic_sample, [31:16] ref_in_phase, [47:32] ref_quadrature
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // [0] cmd
   logic                  req_tuser = CMD_ACCUMULATE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [62:0] sample_energy ... [396:365] samples_taken, [399:397] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // [0] count_full
   logic                  rsp_tuser;

   // predicted accumulator state
   logic [63:0] energy_acc;
   logic [63:0] in_phase_corr_acc;
   logic [63:0] quadrature_corr_acc;
   logic [63:0] in_phase_power_acc;
   logic [63:0] quadrature_power_acc;
   logic [15:0] peak_acc;
   logic [31:0] clip_acc;
   logic [31:0] tally_acc;

   totals_type expected_totals[$];
   int      mismatches = 0;
   int      cycle_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;

   tone_correlation_power_accumulator #(
      .COUNT_BITS(COUNT_BITS_UNDER_TEST)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #5 clock = ~clock;

   // run timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // signed 16x16 product, sign extended to the accumulator width
   function automatic logic [63:0] wide_product(input logic signed [15:0] a,
                                                input logic signed [15:0] b);
      logic signed [63:0] p;
      p = a * b;
      return p;
   endfunction

   // mostly full-range values, with the rails, zero and minus one favoured
   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(15))
         0:       return FULL_SCALE_POS;
         1:       return FULL_SCALE_NEG;
         2:       return 16'sh0000;
         3:       return -16'sd1;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void clear_totals();
      energy_acc           = '0;
      in_phase_corr_acc    = '0;
      quadrature_corr_acc  = '0;
      in_phase_power_acc   = '0;
      quadrature_power_acc = '0;
      peak_acc             = '0;
      clip_acc             = '0;
      tally_acc            = '0;
   endfunction

   // update the predicted sums for one accepted request and queue the totals
   function automatic void accumulate_request(input logic cmd,
                                              input logic signed [15:0] mic,
                                              input logic signed [15:0] ri,
                                              input logic signed [15:0] rq);
      logic [16:0] mag;
      totals_type  t;
      if (cmd == CMD_CLEAR) begin
         clear_totals();
      end else if (tally_acc < COUNT_LIMIT) begin
         energy_acc           += wide_product(mic, mic);
         in_phase_corr_acc    += wide_product(mic, ri);
         quadrature_corr_acc  += wide_product(mic, rq);
         in_phase_power_acc   += wide_product(ri, ri);
         quadrature_power_acc += wide_product(rq, rq);
         // 17 bits so the most negative sample keeps its magnitude
         mag = mic[15] ? (~{1'b1, mic} + 17'd1) : {1'b0, mic};
         if (mag > {1'b0, peak_acc})
            peak_acc = mag[15:0];
         if (mic == FULL_SCALE_POS || mic == FULL_SCALE_NEG)
            clip_acc++;
         tally_acc++;
      end
      t.sample_energy     = energy_acc[62:0];
      t.in_phase_dot      = in_phase_corr_acc;
      t.quadrature_dot    = quadrature_corr_acc;
      t.in_phase_energy   = in_phase_power_acc[62:0];
      t.quadrature_energy = quadrature_power_acc[62:0];
      t.peak_magnitude    = peak_acc;
      t.clipped_samples   = clip_acc;
      t.samples_taken     = tally_acc;
      t.count_full        = (tally_acc == COUNT_LIMIT);
      expected_totals.push_back(t);
   endfunction

   function automatic void compare_field(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // compare one response with the oldest outstanding prediction
   function automatic void check_response(input logic [RSP_DATA_W-1:0] data,
                                          input logic user);
      totals_type want;
      if (expected_totals.size() == 0) begin
         $error("response with no request outstanding");
         mismatches++;
         return;
      end
      want = expected_totals.pop_front();
      compare_field("sample_energy", 64'(want.sample_energy), 64'(data[62:0]));
      compare_field("in_phase_dot", want.in_phase_dot, data[126:63]);
      compare_field("quadrature_dot", want.quadrature_dot, data[190:127]);
      compare_field("in_phase_energy", 64'(want.in_phase_energy), 64'(data[253:191]));
      compare_field("quadrature_energy", 64'(want.quadrature_energy), 64'(data[316:254]));
      compare_field("peak_magnitude", 64'(want.peak_magnitude), 64'(data[332:317]));
      compare_field("clipped_samples", 64'(want.clipped_samples), 64'(data[364:333]));
      compare_field("samples_taken", 64'(want.samples_taken), 64'(data[396:365]));
      compare_field("count_full", 64'(want.count_full), 64'(user));
   endfunction

   // response side: check on each handshake, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_response(rsp_tdata, rsp_tuser);
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // offer one request, optionally after an idle gap, and wait for its acceptance
   task automatic send_request(input logic cmd, input logic signed [15:0] mic,
                               input logic signed [15:0] ri,
                               input logic signed [15:0] rq);
      int gap;
      gap = 0;
      while (gap < 64 && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {rq, ri, mic};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      accumulate_request(cmd, mic, ri, rq);
   endtask

   // rails, sign patterns, clears with live data and peak tracking
   task automatic test_clear_and_extremes();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_request(CMD_CLEAR, FULL_SCALE_POS, FULL_SCALE_NEG, FULL_SCALE_POS);
      send_request(CMD_ACCUMULATE, 16'sh0000, 16'sh0000, 16'sh0000);
      send_request(CMD_ACCUMULATE, FULL_SCALE_POS, FULL_SCALE_POS, FULL_SCALE_POS);
      send_request(CMD_ACCUMULATE, FULL_SCALE_NEG, FULL_SCALE_NEG, FULL_SCALE_NEG);
      send_request(CMD_ACCUMULATE, FULL_SCALE_NEG, FULL_SCALE_POS, FULL_SCALE_NEG);
      send_request(CMD_ACCUMULATE, FULL_SCALE_POS, FULL_SCALE_NEG, FULL_SCALE_POS);
      send_request(CMD_ACCUMULATE, -16'sd1, 16'sd1, -16'sd1);
      send_request(CMD_ACCUMULATE, 16'sd1, -16'sd1, 16'sd1);
      send_request(CMD_ACCUMULATE, 16'sd32766, -16'sd32767, 16'sd32766);
      // clear with live data on the fields
      send_request(CMD_CLEAR, -16'sd1234, 16'sd4321, -16'sd77);
      // just short of full scale, then a smaller one: peak must hold
      send_request(CMD_ACCUMULATE, -16'sd32767, 16'sd300, -16'sd300);
      send_request(CMD_ACCUMULATE, 16'sd100, -16'sd5, 16'sd5);
      // most negative sample sets the peak to 32768
      send_request(CMD_ACCUMULATE, FULL_SCALE_NEG, 16'sd2, 16'sd3);
      send_request(CMD_ACCUMULATE, FULL_SCALE_POS, -16'sd2, -16'sd3);
      send_request(CMD_ACCUMULATE, 16'sh5555, 16'shaaaa, 16'sh0f0f);
      send_request(CMD_ACCUMULATE, 16'shaaaa, 16'sh5555, 16'shf0f0);
      send_request(CMD_CLEAR, 16'sh0000, 16'sh0000, 16'sh0000);
      send_request(CMD_ACCUMULATE, 16'sh0000, 16'sh0000, 16'sh0000);
   endtask

   task automatic run_random_phase(input int items, input int send_pct, input int recv_pct);
      logic cmd;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (items) begin
         cmd = ($urandom_range(24) == 0) ? CMD_CLEAR : CMD_ACCUMULATE;
         send_request(cmd, pick_sample(), pick_sample(), pick_sample());
      end
   endtask

   // random runs of accumulation broken by occasional clears
   task automatic test_random_traffic();
      run_random_phase(RANDOM_ITEMS_PER_PHASE, 20, 78);
      run_random_phase(RANDOM_ITEMS_PER_PHASE, 78, 20);
      run_random_phase(RANDOM_ITEMS_PER_PHASE, 0, 0);
   endtask

   // sequence of tests and end of run
   initial begin
      clear_totals();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_clear_and_extremes();
      test_random_traffic();
      req_tvalid <= 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (expected_totals.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
